// File: rtl/i2cs_pkg.sv
// ---------------------------------------------------------------------------
// i2cs_pkg: shared types and constants of the I2C transaction sequencer
// Operation, action and status codes, write store geometry and the
// structures passed between the sequencer modules.
// ---------------------------------------------------------------------------
package i2cs_pkg;

	// write store geometry
	localparam int WRITE_DEPTH = 16;
	localparam int STORE_AW    = $clog2(WRITE_DEPTH);

	// configuration register indexes
	localparam logic [1:0] REG_SLAVE_ADDR  = 2'd0;
	localparam logic [1:0] REG_WRITE_COUNT = 2'd1;
	localparam logic [1:0] REG_READ_COUNT  = 2'd2;
	localparam logic [1:0] REG_NO_RESTART  = 2'd3;

	typedef enum logic [1:0] {
		OP_LOAD      = 2'd0,
		OP_START     = 2'd1,
		OP_BYTE_DONE = 2'd2,
		OP_POLL      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE       = 3'd0,
		ACT_ADDR_WRITE = 3'd1,
		ACT_SEND       = 3'd2,
		ACT_ADDR_READ  = 3'd3,
		ACT_RECEIVE    = 3'd4,
		ACT_STOP       = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_BUSY  = 2'd1,
		ST_DONE  = 2'd2,
		ST_ERROR = 2'd3
	} status_t;

	// transaction phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_BUSY  = 4'b0010,
		PH_DONE  = 4'b0100,
		PH_ERROR = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [6:0] dev_addr;
		logic [4:0] write_count;
		logic [7:0] read_count;
		logic       read_without_restart;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] load_index;
		logic [7:0] load_byte;
		logic       slave_nacked;
		logic [7:0] received_byte;
	} item_t;

	typedef struct packed {
		act_t       action;
		logic [7:0] tx_byte;
		logic       use_mem;
		logic       set_nack;
		logic       rx_valid;
		logic [7:0] rx_index;
		logic [7:0] rx_byte;
		status_t    status;
		logic       done_pulse;
	} res_t;

	// write store access
	typedef struct packed {
		logic                we;
		logic [STORE_AW-1:0] waddr;
		logic [7:0]          wdata;
		logic                re;
		logic [STORE_AW-1:0] raddr;
	} mem_req_t;

endpackage

// File: rtl/i2cs_req_if.sv
// ---------------------------------------------------------------------------
// i2cs_req_if: input item channel
// Valid/ready channel carrying one sequencer input item.
// ---------------------------------------------------------------------------
interface i2cs_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [3:0] load_index;
	logic [7:0] load_byte;
	logic       slave_nacked;
	logic [7:0] received_byte;

	modport source (
		output valid, op, load_index, load_byte, slave_nacked, received_byte,
		input  ready
	);
	modport sink (
		input  valid, op, load_index, load_byte, slave_nacked, received_byte,
		output ready
	);
endinterface

// File: rtl/i2cs_rsp_if.sv
// ---------------------------------------------------------------------------
// i2cs_rsp_if: result channel
// Valid/ready channel carrying one action for the byte-level I2C core.
// ---------------------------------------------------------------------------
interface i2cs_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] tx_byte;
	logic       set_nack;
	logic       rx_valid;
	logic [7:0] rx_index;
	logic [7:0] rx_byte;
	logic [1:0] status;
	logic       done_pulse;

	modport source (
		output valid, action, tx_byte, set_nack, rx_valid, rx_index, rx_byte,
		       status, done_pulse,
		input  ready
	);
	modport sink (
		input  valid, action, tx_byte, set_nack, rx_valid, rx_index, rx_byte,
		       status, done_pulse,
		output ready
	);
endinterface

// File: rtl/i2cs_cfg_if.sv
// ---------------------------------------------------------------------------
// i2cs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface i2cs_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: rtl/i2c_master_transaction_sequencer.sv
// ---------------------------------------------------------------------------
// i2c_master_transaction_sequencer: I2C write-then-read transaction sequencer
// Steps a byte-level I2C core through a write phase, an optional repeated
// start and a read phase, one action per input item.
// ---------------------------------------------------------------------------
// Usage
//   req: input items (load write byte, start, byte complete, status poll).
//   rsp: one result per item: action for the I2C core, tx byte, set-NACK,
//        received byte with index, status and done pulse.
//   cfg: register writes, always ready; write only while no transfer is
//        in flight.
// Timing
//   An accepted item is registered in the read stage while the write store
//   is read through its registered read port; it then loads the output
//   register, from which it transfers on rsp. One item per cycle is
//   sustained while rsp does not stall; the byte counters and phase update in
//   the accepting cycle so consecutive items see them.
// Stall
//   While rsp is stalled the output register holds; the read stage can take
//   one more item, after which req.ready drops until rsp moves again.
// Reset
//   arst_n clears the phase to idle, the counters and configuration to zero
//   and sets transmit mode. The write store is not cleared; entries are
//   valid once loaded.
// ---------------------------------------------------------------------------
module i2c_master_transaction_sequencer
	import i2cs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	i2cs_req_if.sink   req,
	i2cs_rsp_if.source rsp,
	i2cs_cfg_if.sink   cfg
);

	cfg_t       cfg_q;
	item_t      item;
	res_t       res;
	mem_req_t   mem;
	logic [7:0] mem_rdata;
	logic       accept;
	logic       s1_adv;
	logic       valid_s1;
	res_t       res_s1;
	res_t       res_fwd;
	logic       out_valid_q;
	res_t       out_q;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SLAVE_ADDR:  cfg_q.dev_addr             <= cfg.data[6:0];
				REG_WRITE_COUNT: cfg_q.write_count          <= cfg.data[4:0];
				REG_READ_COUNT:  cfg_q.read_count           <= cfg.data;
				REG_NO_RESTART:  cfg_q.read_without_restart <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// input transfer
	assign s1_adv    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_adv;
	assign accept    = req.valid && req.ready;

	assign item.op            = op_t'(req.op);
	assign item.load_index    = req.load_index;
	assign item.load_byte     = req.load_byte;
	assign item.slave_nacked  = req.slave_nacked;
	assign item.received_byte = req.received_byte;

	i2cs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.res    (res),
		.mem    (mem)
	);

	// store accesses only on an accepted item
	mem_req_t mem_gated;

	always_comb begin
		mem_gated    = mem;
		mem_gated.we = mem.we && accept;
		mem_gated.re = mem.re && accept;
	end

	i2cs_store u_store (
		.clk   (clk),
		.req   (mem_gated),
		.rdata (mem_rdata)
	);

	// store read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// merge the store byte into a send result
	always_comb begin
		res_fwd = res_s1;
		if (res_s1.use_mem) begin
			res_fwd.tx_byte = mem_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res_fwd;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.action     = out_q.action;
	assign rsp.tx_byte    = out_q.tx_byte;
	assign rsp.set_nack   = out_q.set_nack;
	assign rsp.rx_valid   = out_q.rx_valid;
	assign rsp.rx_index   = out_q.rx_index;
	assign rsp.rx_byte    = out_q.rx_byte;
	assign rsp.status     = out_q.status;
	assign rsp.done_pulse = out_q.done_pulse;

	// a done pulse always reports the done status
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.done_pulse |-> rsp.status == ST_DONE)
		else $error("done pulse without done status");

	// a received byte goes with no action or a stop
	a_rx_action: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.rx_valid |-> (rsp.action == ACT_NONE || rsp.action == ACT_STOP))
		else $error("received byte with a transmit action");

	// a read stage result moves into an empty output register
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("read stage result not forwarded");

	// no input transfer while both stages are full and the output stalls
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !rsp.ready |-> !req.ready)
		else $error("input taken while pipeline full");

endmodule

// File: rtl/i2cs_store.sv
// ---------------------------------------------------------------------------
// i2cs_store: write byte store
// Single-write, single-read memory with a registered read port.
// ---------------------------------------------------------------------------
module i2cs_store
	import i2cs_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output logic [7:0] rdata
);

	logic [7:0] mem_q [WRITE_DEPTH];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// read port, registered, holds between reads
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/i2cs_ctrl.sv
// ---------------------------------------------------------------------------
// i2cs_ctrl: transaction control
// Holds the phase and byte counters, decodes each accepted item into one
// result and drives the write store accesses.
// ---------------------------------------------------------------------------
module i2cs_ctrl
	import i2cs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  item_t    item,
	input  cfg_t     cfg,
	output res_t     res,
	output mem_req_t mem
);

	phase_t     ph_q, ph_d;
	logic       tm_q, tm_d;
	logic       rp_q, rp_d;
	logic [4:0] bw_q, bw_d;
	logic [7:0] br_q, br_d;
	logic [4:0] wc;
	logic [7:0] last_idx;
	logic [7:0] before_last_idx;

	function automatic status_t phase_code(input phase_t ph);
		status_t s;
		case (ph)
			PH_IDLE:  s = ST_IDLE;
			PH_BUSY:  s = ST_BUSY;
			PH_DONE:  s = ST_DONE;
			PH_ERROR: s = ST_ERROR;
			default:  s = ST_IDLE;
		endcase
		return s;
	endfunction

	// write count clamped to the store depth
	assign wc = (cfg.write_count > 5'(WRITE_DEPTH)) ? 5'(WRITE_DEPTH) : cfg.write_count;
	assign last_idx        = cfg.read_count - 8'd1;
	assign before_last_idx = cfg.read_count - 8'd2;

	// item decode and next state
	always_comb begin
		ph_d = ph_q;
		tm_d = tm_q;
		rp_d = rp_q;
		bw_d = bw_q;
		br_d = br_q;
		res  = '0;
		res.action = ACT_NONE;
		res.status = ST_IDLE;
		mem  = '0;
		case (item.op)
			OP_LOAD: begin
				mem.we    = (32'(item.load_index) < WRITE_DEPTH);
				mem.waddr = item.load_index[STORE_AW-1:0];
				mem.wdata = item.load_byte;
			end
			OP_START: begin
				ph_d = PH_BUSY;
				tm_d = 1'b1;
				rp_d = cfg.read_without_restart;
				bw_d = '0;
				br_d = '0;
				res.action  = ACT_ADDR_WRITE;
				res.tx_byte = {cfg.dev_addr, 1'b0};
			end
			OP_BYTE_DONE: begin
				if (ph_q == PH_BUSY) begin
					if (tm_q) begin
						if (bw_q == wc) begin
							// write phase finished
							if (cfg.read_count != 8'd0) begin
								if (item.slave_nacked) begin
									ph_d       = PH_ERROR;
									res.action = ACT_STOP;
								end else if (rp_q) begin
									tm_d         = 1'b0;
									res.action   = ACT_RECEIVE;
									res.set_nack = (cfg.read_count == 8'd1);
								end else begin
									res.action  = ACT_ADDR_READ;
									res.tx_byte = {cfg.dev_addr, 1'b1};
									rp_d        = 1'b1;
								end
							end else begin
								ph_d           = PH_DONE;
								res.action     = ACT_STOP;
								res.done_pulse = 1'b1;
							end
						end else if (bw_q < wc) begin
							if (item.slave_nacked) begin
								ph_d       = PH_ERROR;
								res.action = ACT_STOP;
							end else begin
								// byte comes from the store's registered read port in the read stage
								res.action  = ACT_SEND;
								res.use_mem = 1'b1;
								mem.re      = 1'b1;
								mem.raddr   = bw_q[STORE_AW-1:0];
								bw_d        = bw_q + 5'd1;
							end
						end
					end else begin
						// receive phase
						res.rx_valid = 1'b1;
						res.rx_index = br_q;
						res.rx_byte  = item.received_byte;
						if (br_q == last_idx) begin
							res.action     = ACT_STOP;
							ph_d           = PH_DONE;
							res.done_pulse = 1'b1;
						end else if (br_q == before_last_idx) begin
							res.set_nack = 1'b1;
						end
						br_d = br_q + 8'd1;
					end
				end
			end
			OP_POLL: begin
				if (ph_q == PH_DONE || ph_q == PH_ERROR) begin
					ph_d = PH_IDLE;
				end
			end
			default: ;
		endcase
		// a poll reports the status before it clears
		res.status = (item.op == OP_POLL) ? phase_code(ph_q) : phase_code(ph_d);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			tm_q <= 1'b1;
			rp_q <= 1'b0;
			bw_q <= '0;
			br_q <= '0;
		end else if (accept) begin
			ph_q <= ph_d;
			tm_q <= tm_d;
			rp_q <= rp_d;
			bw_q <= bw_d;
			br_q <= br_d;
		end
	end

endmodule

// File: sim/tb_i2c_master_transaction_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_i2c_master_transaction_sequencer: self-checking bench for the sequencer
// Sends load, start, byte-complete and poll transfers with random gaps and
// random back-pressure. A behavioral copy of the sequencer predicts the
// result of every accepted transfer, and each result is compared field by
// field in order. The run covers directed corner cases first, then random
// transactions under several register settings and idle mixes.
// ---------------------------------------------------------------------------
module tb_i2c_master_transaction_sequencer;
	import i2cs_pkg::*;

	// one result as seen on the result channel
	typedef struct packed {
		act_t       action;
		logic [7:0] tx_byte;
		logic       set_nack;
		logic       rx_valid;
		logic [7:0] rx_index;
		logic [7:0] rx_byte;
		status_t    status;
		logic       done_pulse;
	} seq_out_t;

	// predicts the sequencer and holds the results still owed
	class seq_scoreboard;
		logic [6:0]  slave_addr;
		logic [4:0]  wr_count;
		logic [7:0]  rd_count;
		logic        no_restart;
		status_t     phase;
		logic        tx_mode;
		logic        rd_phase;
		logic [4:0]  n_written;
		logic [7:0]  n_read;
		logic [7:0]  store [WRITE_DEPTH];
		seq_out_t    pending [$];
		int unsigned n_checked;
		int unsigned n_errors;
		int unsigned n_done;
		int unsigned n_aborted;

		function new();
			slave_addr = '0;
			wr_count   = '0;
			rd_count   = '0;
			no_restart = 1'b0;
			phase      = ST_IDLE;
			tx_mode    = 1'b1;
			rd_phase   = 1'b0;
			n_written  = '0;
			n_read     = '0;
			n_checked  = 0;
			n_errors   = 0;
			n_done     = 0;
			n_aborted  = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] data);
			case (idx)
				REG_SLAVE_ADDR:  slave_addr = data[6:0];
				REG_WRITE_COUNT: wr_count   = data[4:0];
				REG_READ_COUNT:  rd_count   = data;
				REG_NO_RESTART:  no_restart = data[0];
				default: ;
			endcase
		endfunction

		// step the prediction for one accepted item
		function void note_input(item_t it);
			seq_out_t   r;
			logic [4:0] wc;
			logic [7:0] last_idx;
			r        = '0;
			wc       = (wr_count > 5'(WRITE_DEPTH)) ? 5'(WRITE_DEPTH) : wr_count;
			last_idx = rd_count - 8'd1;
			case (it.op)
				OP_LOAD: begin
					if (int'(it.load_index) < WRITE_DEPTH)
						store[it.load_index] = it.load_byte;
				end
				OP_START: begin
					phase     = ST_BUSY;
					tx_mode   = 1'b1;
					rd_phase  = no_restart;
					n_written = '0;
					n_read    = '0;
					r.action  = ACT_ADDR_WRITE;
					r.tx_byte = {slave_addr, 1'b0};
				end
				OP_BYTE_DONE: begin
					if (phase == ST_BUSY) begin
						if (tx_mode) begin
							// write phase finished: read, restart or stop
							if (n_written == wc) begin
								if (rd_count != 8'd0) begin
									if (it.slave_nacked) begin
										phase    = ST_ERROR;
										r.action = ACT_STOP;
										n_aborted++;
									end else if (rd_phase) begin
										tx_mode    = 1'b0;
										r.action   = ACT_RECEIVE;
										r.set_nack = (rd_count == 8'd1);
									end else begin
										r.action  = ACT_ADDR_READ;
										r.tx_byte = {slave_addr, 1'b1};
										rd_phase  = 1'b1;
									end
								end else begin
									phase        = ST_DONE;
									r.action     = ACT_STOP;
									r.done_pulse = 1'b1;
									n_done++;
								end
							end else if (n_written < wc) begin
								if (it.slave_nacked) begin
									phase    = ST_ERROR;
									r.action = ACT_STOP;
									n_aborted++;
								end else begin
									r.action  = ACT_SEND;
									r.tx_byte = store[n_written];
									n_written = n_written + 5'd1;
								end
							end
						end else begin
							// receive mode
							r.rx_valid = 1'b1;
							r.rx_index = n_read;
							r.rx_byte  = it.received_byte;
							if (n_read == last_idx) begin
								r.action     = ACT_STOP;
								phase        = ST_DONE;
								r.done_pulse = 1'b1;
								n_done++;
							end else if (n_read == last_idx - 8'd1) begin
								r.set_nack = 1'b1;
							end
							n_read = n_read + 8'd1;
						end
					end
				end
				default: ;
			endcase
			// a poll reports the status before clearing it
			r.status = phase;
			if (it.op == OP_POLL && (phase == ST_DONE || phase == ST_ERROR))
				phase = ST_IDLE;
			pending.push_back(r);
		endfunction

		// compare one result with the oldest prediction
		function void check_result(seq_out_t got);
			seq_out_t want;
			string    bad;
			n_checked++;
			if (pending.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("[%0t] result with none pending: action %0d status %0d",
						$time, got.action, got.status);
				return;
			end
			want = pending.pop_front();
			bad  = "";
			if (got.action !== want.action)         bad = {bad, " action"};
			if (got.tx_byte !== want.tx_byte)       bad = {bad, " tx_byte"};
			if (got.set_nack !== want.set_nack)     bad = {bad, " set_nack"};
			if (got.rx_valid !== want.rx_valid)     bad = {bad, " rx_valid"};
			if (got.rx_index !== want.rx_index)     bad = {bad, " rx_index"};
			if (got.rx_byte !== want.rx_byte)       bad = {bad, " rx_byte"};
			if (got.status !== want.status)         bad = {bad, " status"};
			if (got.done_pulse !== want.done_pulse) bad = {bad, " done_pulse"};
			if (bad != "") begin
				n_errors++;
				if (n_errors <= 10) begin
					$display("[%0t] mismatch in%s", $time, bad);
					$display({"  expected act=%0d tx=%02h nack=%0b rxv=%0b",
						" idx=%0d rx=%02h st=%0d done=%0b"},
						want.action, want.tx_byte, want.set_nack, want.rx_valid,
						want.rx_index, want.rx_byte, want.status, want.done_pulse);
					$display({"  actual   act=%0d tx=%02h nack=%0b rxv=%0b",
						" idx=%0d rx=%02h st=%0d done=%0b"},
						got.action, got.tx_byte, got.set_nack, got.rx_valid,
						got.rx_index, got.rx_byte, got.status, got.done_pulse);
				end
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	int unsigned   src_idle_pct;
	int unsigned   dst_idle_pct;
	int unsigned   n_sent;
	bit            clear_rc_armed;
	seq_scoreboard sb;

	i2cs_req_if req_ch ();
	i2cs_rsp_if rsp_ch ();
	i2cs_cfg_if cfg_ch ();

	i2c_master_transaction_sequencer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// clock
	always #6 clk = ~clk;

	// result side back-pressure
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= dst_idle_pct);

	// result monitor
	always @(posedge clk) begin : result_monitor
		seq_out_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.action     = act_t'(rsp_ch.action);
			got.tx_byte    = rsp_ch.tx_byte;
			got.set_nack   = rsp_ch.set_nack;
			got.rx_valid   = rsp_ch.rx_valid;
			got.rx_index   = rsp_ch.rx_index;
			got.rx_byte    = rsp_ch.rx_byte;
			got.status     = status_t'(rsp_ch.status);
			got.done_pulse = rsp_ch.done_pulse;
			sb.check_result(got);
		end
	end

	// one item transfer, with a random gap first; valid stays high afterwards
	task automatic send(op_t op, logic [3:0] idx, logic [7:0] ld, logic nack,
		logic [7:0] rxb);
		item_t it;
		it.op            = op;
		it.load_index    = idx;
		it.load_byte     = ld;
		it.slave_nacked  = nack;
		it.received_byte = rxb;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.op            <= op;
		req_ch.load_index    <= idx;
		req_ch.load_byte     <= ld;
		req_ch.slave_nacked  <= nack;
		req_ch.received_byte <= rxb;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_input(it);
		n_sent++;
	endtask

	// any op with any field values
	task automatic send_stray();
		send(op_t'($urandom_range(3)), 4'($urandom), 8'($urandom), 1'($urandom),
			8'($urandom));
	endtask

	// register write transfer
	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// stop sending and wait for every owed result, plus the pipeline depth
	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// one transaction from start until it leaves busy, with stray traffic
	task automatic run_transaction(int unsigned nack_pct);
		int unsigned roll;
		int unsigned steps;
		steps = 0;
		while ($urandom_range(9) < 2)
			send_stray();
		send(OP_START, 4'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
		while (sb.phase == ST_BUSY && steps < 600) begin
			// clear the read count once the receive phase has begun
			if (clear_rc_armed && !sb.tx_mode) begin
				drain_results();
				write_reg(REG_READ_COUNT, 8'd0);
				clear_rc_armed = 1'b0;
			end
			roll = $urandom_range(99);
			if (roll < 3)
				send_stray();
			else if (roll < 6)
				send(OP_POLL, 4'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
			else if (roll < 8)
				send(OP_LOAD, 4'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
			else
				send(OP_BYTE_DONE, 4'($urandom), 8'($urandom),
					($urandom_range(99) < nack_pct), 8'($urandom));
			steps++;
		end
		if ($urandom_range(3) != 0)
			send(OP_POLL, 4'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// stimulus
	initial begin : stimulus
		int unsigned stage;
		int unsigned q;
		int unsigned budget;
		logic [7:0]  cfg_addr;
		logic [4:0]  cfg_wr;
		logic [7:0]  cfg_rd;
		logic        cfg_nr;
		sb             = new();
		n_sent         = 0;
		clear_rc_armed = 1'b0;
		src_idle_pct   = 15;
		dst_idle_pct   = 62;
		arst_n         = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.op            = OP_LOAD;
		req_ch.load_index    = '0;
		req_ch.load_byte     = '0;
		req_ch.slave_nacked  = 1'b0;
		req_ch.received_byte = '0;
		rsp_ch.ready         = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = REG_SLAVE_ADDR;
		cfg_ch.data          = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: top address, two writes, two reads with repeated start
		write_reg(REG_SLAVE_ADDR, 8'h7F);
		write_reg(REG_WRITE_COUNT, 8'd2);
		write_reg(REG_READ_COUNT, 8'd2);
		write_reg(REG_NO_RESTART, 8'd0);
		// fill the whole write store so no send ever reads an unloaded slot
		for (int i = 0; i < WRITE_DEPTH; i++)
			send(OP_LOAD, 4'(i), (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'(i * 37 + 5),
				1'b0, 8'h00);
		send(OP_POLL, 4'd0, 8'd0, 1'b0, 8'd0);
		send(OP_BYTE_DONE, 4'd0, 8'd0, 1'b1, 8'hFF);
		send(OP_START, 4'd0, 8'd0, 1'b0, 8'd0);
		repeat (4) send(OP_BYTE_DONE, 4'd0, 8'd0, 1'b0, 8'd0);
		send(OP_BYTE_DONE, 4'hF, 8'hFF, 1'b1, 8'hFF);
		send(OP_BYTE_DONE, 4'd0, 8'd0, 1'b0, 8'h00);
		send(OP_POLL, 4'd0, 8'd0, 1'b0, 8'd0);
		// slave nack while bytes remain to be written
		send(OP_START, 4'd0, 8'd0, 1'b0, 8'd0);
		send(OP_BYTE_DONE, 4'd0, 8'd0, 1'b1, 8'd0);
		send(OP_POLL, 4'd0, 8'd0, 1'b0, 8'd0);
		// start while busy, then lower the write count below the counter
		send(OP_START, 4'd0, 8'd0, 1'b0, 8'd0);
		send(OP_BYTE_DONE, 4'd0, 8'd0, 1'b0, 8'd0);
		send(OP_START, 4'd0, 8'd0, 1'b0, 8'd0);
		repeat (2) send(OP_BYTE_DONE, 4'd0, 8'd0, 1'b0, 8'd0);
		drain_results();
		write_reg(REG_WRITE_COUNT, 8'd1);
		send(OP_BYTE_DONE, 4'd0, 8'd0, 1'b0, 8'd0);
		// write-only: a nack on the last byte still ends as done
		drain_results();
		write_reg(REG_WRITE_COUNT, 8'd0);
		write_reg(REG_READ_COUNT, 8'd0);
		send(OP_START, 4'd0, 8'd0, 1'b0, 8'd0);
		send(OP_BYTE_DONE, 4'd0, 8'd0, 1'b1, 8'd0);
		// single byte read straight after the address, no repeated start
		drain_results();
		write_reg(REG_READ_COUNT, 8'd1);
		write_reg(REG_NO_RESTART, 8'd1);
		send(OP_START, 4'd0, 8'd0, 1'b0, 8'd0);
		send(OP_BYTE_DONE, 4'd0, 8'd0, 1'b0, 8'd0);
		send(OP_BYTE_DONE, 4'd0, 8'd0, 1'b0, 8'hA5);
		send(OP_POLL, 4'd0, 8'd0, 1'b0, 8'd0);

		// random transactions: three idle mixes, four register settings each
		for (stage = 0; stage < 3; stage++) begin
			src_idle_pct = (stage == 0) ? 15 : (stage == 1) ? 62 : 0;
			dst_idle_pct = (stage == 0) ? 62 : (stage == 1) ? 15 : 0;
			for (int p = 0; p < 4; p++) begin
				q        = stage * 4 + p;
				cfg_addr = 8'($urandom);
				cfg_wr   = 5'($urandom_range(0, 4));
				cfg_rd   = 8'($urandom_range(0, 6));
				cfg_nr   = 1'($urandom);
				if ($urandom_range(4) == 0)
					cfg_wr = 5'($urandom_range(5, 31));
				// extremes first, then the read count cleared mid receive
				case (q)
					0: begin
						cfg_addr = 8'h7F;
						cfg_wr   = 5'd16;
						cfg_rd   = 8'd1;
						cfg_nr   = 1'b0;
					end
					1: begin
						cfg_addr = 8'h00;
						cfg_wr   = 5'd0;
						cfg_rd   = 8'd0;
						cfg_nr   = 1'b1;
					end
					2: begin
						cfg_wr = 5'd31;
						cfg_rd = 8'd2;
					end
					3: begin
						cfg_wr = 5'd0;
						cfg_rd = 8'd255;
						cfg_nr = 1'b0;
					end
					4: begin
						cfg_rd         = 8'd3;
						clear_rc_armed = 1'b1;
					end
					default: ;
				endcase
				drain_results();
				write_reg(REG_SLAVE_ADDR, cfg_addr);
				write_reg(REG_WRITE_COUNT, {3'b000, cfg_wr});
				write_reg(REG_READ_COUNT, cfg_rd);
				write_reg(REG_NO_RESTART, {7'd0, cfg_nr});
				budget = n_sent + 45;
				while (n_sent < budget) begin
					run_transaction(clear_rc_armed ? 0 : 5);
					// now and then hold off until every result is back
					if ($urandom_range(15) == 0)
						drain_results();
				end
			end
		end

		drain_results();
		$display("run: %0d item transfers, %0d results checked, %0d done, %0d nack stops",
			n_sent, sb.n_checked, sb.n_done, sb.n_aborted);
		$display("run: directed corners plus 12 register settings under three idle mixes");
		if (sb.n_errors == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.n_errors, sb.pending.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#5000000;
		$display("timeout with %0d results still pending", sb.pending.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
